// ===== hdl/fcba_pkg.sv =====
package fcba_pkg;

  typedef enum logic [2:0] {
    CMD_ALLOC      = 3'd0,
    CMD_FREE_BLOCK = 3'd1,
    CMD_FREE_CHAIN = 3'd2,
    CMD_READ_LINK  = 3'd3,
    CMD_SET_LINK   = 3'd4,
    CMD_WALK       = 3'd5
  } command_t;

  localparam logic CFG_BLOCK_COUNT  = 1'b0;
  localparam logic CFG_FIRST_USABLE = 1'b1;

  localparam logic [16:0] BLOCK_COUNT_RESET  = 17'd65536;
  localparam logic [15:0] FIRST_USABLE_RESET = 16'd266;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] block_number;
    logic [15:0] link_value;
    logic [15:0] step_count;
    logic        extend_chain;
  } in_item_t;

  typedef struct packed {
    logic [15:0] result_block;
    logic        status;
    logic [16:0] free_blocks;
  } out_item_t;

  // one table entry: used bit and next-block link
  typedef struct packed {
    logic        used;
    logic [15:0] link;
  } entry_t;

endpackage

// ===== hdl/fcba_ram.sv =====
module fcba_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/fat_chain_block_allocator.sv =====
// Block allocator over a table of used bits and next-block links.
// Commands arrive one beat at a time on in_valid/in_stall with payload
// in_data; each command gives exactly one result beat on
// out_valid/out_stall with payload out_data.
// Configuration (block_count, first_usable_block) is written through
// cfg_we/cfg_index/cfg_data; the user must write while the block is idle (not enforced).
// After reset a clearing pass writes every table entry, one per cycle:
// in_stall stays high until the pass is done.
// All table reads go through the single table read port, one read per
// cycle. Read/set link and free block visit one entry; allocate scans
// the usable range for a free block; free chain and walk follow links,
// and a walk that extends the chain also runs allocation scans.
// One command is in work at a time; in_stall is low only while idle.
// A finished result waits in the output register while out_stall is high;
// the next command is taken meanwhile and its result holds until the
// earlier beat is taken.
module fat_chain_block_allocator #(
  parameter int NUM_BLOCKS = 65536
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  fcba_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output fcba_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [16:0]          cfg_data
);
  import fcba_pkg::*;

  localparam int AW = $clog2(NUM_BLOCKS);
  localparam logic [16:0] NUM_L = 17'(NUM_BLOCKS);
  localparam logic [16:0] LAST_L = 17'(NUM_BLOCKS - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ISSUE, S_FREE_CHK, S_READ_CHK, S_SET_CHK,
    S_CHAIN, S_CHAIN_CHK, S_WALK, S_WALK_CHK, S_SCAN, S_SCAN_CHK,
    S_LINK_WR, S_DONE
  } state_t;

  state_t      state;
  logic [16:0] block_count;
  logic [15:0] first_usable;
  logic [16:0] used_count;
  logic [2:0]  cmd;
  logic [15:0] cur;
  logic [15:0] link_val;
  logic [15:0] steps;
  logic        extend;
  logic [16:0] n;
  logic [16:0] scan_b;
  logic        walk_mode;
  logic        cur_used;
  logic [15:0] res;
  logic        st;

  logic        we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  entry_t      wdata;
  entry_t      rdata;

  logic [16:0] range_e;
  logic [16:0] range_s;
  logic [16:0] range_size;
  logic [16:0] free_now;
  logic [16:0] cur_w;
  logic [16:0] lim;
  logic        cur_in_range;
  logic        cur_in_table;

  fcba_ram #(.WIDTH($bits(entry_t)), .DEPTH(NUM_BLOCKS)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    range_e      = (block_count < NUM_L) ? block_count : NUM_L;
    range_s      = (first_usable == 16'd0) ? 17'd1 : {1'b0, first_usable};
    range_size   = (range_e > range_s) ? range_e - range_s : 17'd0;
    free_now     = (range_size > used_count) ? range_size - used_count : 17'd0;
    cur_w        = {1'b0, cur};
    cur_in_table = cur_w < NUM_L;
    cur_in_range = (cur_w >= range_s) && (cur_w < range_e);
    lim          = ({1'b0, steps} < NUM_L) ? {1'b0, steps} : NUM_L;
  end

  always_comb begin
    we    = 1'b0;
    waddr = cur[AW-1:0];
    wdata = '0;
    raddr = (state == S_SCAN) ? scan_b[AW-1:0] : cur[AW-1:0];
    case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = scan_b[AW-1:0];
      end
      S_FREE_CHK: we = 1'b1;
      S_SET_CHK: begin
        we         = 1'b1;
        wdata.used = rdata.used;
        wdata.link = link_val;
      end
      S_CHAIN_CHK: we = cur_in_range;
      S_SCAN_CHK: begin
        we         = !rdata.used;
        waddr      = scan_b[AW-1:0];
        wdata.used = 1'b1;
      end
      S_LINK_WR: begin
        we         = cur_in_table;
        // the new block may be the current one when the chain runs through free blocks
        wdata.used = (scan_b == cur_w) ? 1'b1 : cur_used;
        wdata.link = scan_b[15:0];
      end
      default: we = 1'b0;
    endcase
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      scan_b       <= '0;
      used_count   <= '0;
      block_count  <= BLOCK_COUNT_RESET;
      first_usable <= FIRST_USABLE_RESET;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BLOCK_COUNT:  block_count  <= cfg_data;
          CFG_FIRST_USABLE: first_usable <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          scan_b <= scan_b + 17'd1;
          if (scan_b == LAST_L) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd      <= in_data.command;
            cur      <= in_data.block_number;
            link_val <= in_data.link_value;
            steps    <= in_data.step_count;
            extend   <= in_data.extend_chain;
            n        <= '0;
            res      <= '0;
            st       <= 1'b0;
            case (in_data.command)
              CMD_ALLOC: begin
                scan_b    <= range_s;
                walk_mode <= 1'b0;
                state     <= S_SCAN;
              end
              CMD_FREE_BLOCK: begin
                if (({1'b0, in_data.block_number} >= range_s) &&
                    ({1'b0, in_data.block_number} < range_e)) begin
                  state <= S_ISSUE;
                end else begin
                  state <= S_DONE;
                end
              end
              CMD_FREE_CHAIN: state <= S_CHAIN;
              CMD_READ_LINK, CMD_SET_LINK: begin
                state <= ({1'b0, in_data.block_number} < NUM_L) ? S_ISSUE : S_DONE;
              end
              CMD_WALK: state <= S_WALK;
              default:  state <= S_DONE;
            endcase
          end
        end
        S_ISSUE: begin
          case (cmd)
            CMD_FREE_BLOCK: state <= S_FREE_CHK;
            CMD_READ_LINK:  state <= S_READ_CHK;
            default:        state <= S_SET_CHK;
          endcase
        end
        S_FREE_CHK: begin
          if (rdata.used && used_count != 17'd0) begin
            used_count <= used_count - 17'd1;
          end
          state <= S_DONE;
        end
        S_READ_CHK: begin
          res   <= rdata.link;
          state <= S_DONE;
        end
        S_SET_CHK: state <= S_DONE;
        S_CHAIN: begin
          if (cur == 16'd0 || n >= NUM_L) begin
            state <= S_DONE;
          end else if (!cur_in_table) begin
            cur <= '0;
            n   <= n + 17'd1;
          end else begin
            state <= S_CHAIN_CHK;
          end
        end
        S_CHAIN_CHK: begin
          if (cur_in_range && rdata.used && used_count != 17'd0) begin
            used_count <= used_count - 17'd1;
          end
          cur   <= rdata.link;
          n     <= n + 17'd1;
          state <= S_CHAIN;
        end
        S_WALK: begin
          if (n == lim) begin
            if ({1'b0, steps} > NUM_L) begin
              st <= 1'b1;
            end else begin
              res <= cur;
            end
            state <= S_DONE;
          end else if (!cur_in_table) begin
            // link reads as zero here
            if (!extend) begin
              st    <= 1'b1;
              state <= S_DONE;
            end else begin
              cur_used  <= 1'b0;
              scan_b    <= range_s;
              walk_mode <= 1'b1;
              state     <= S_SCAN;
            end
          end else begin
            state <= S_WALK_CHK;
          end
        end
        S_WALK_CHK: begin
          if (rdata.link != 16'd0) begin
            cur   <= rdata.link;
            n     <= n + 17'd1;
            state <= S_WALK;
          end else if (!extend) begin
            st    <= 1'b1;
            state <= S_DONE;
          end else begin
            cur_used  <= rdata.used;
            scan_b    <= range_s;
            walk_mode <= 1'b1;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_b >= range_e) begin
            res   <= '0;
            st    <= 1'b1;
            state <= S_DONE;
          end else begin
            state <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          if (!rdata.used) begin
            used_count <= used_count + 17'd1;
            if (walk_mode) begin
              state <= S_LINK_WR;
            end else begin
              res   <= scan_b[15:0];
              state <= S_DONE;
            end
          end else begin
            scan_b <= scan_b + 17'd1;
            state  <= S_SCAN;
          end
        end
        S_LINK_WR: begin
          cur   <= scan_b[15:0];
          n     <= n + 17'd1;
          state <= S_WALK;
        end
        S_DONE: begin
          // hold until the previous beat is taken
          if (!out_valid || !out_stall) begin
            out_valid             <= 1'b1;
            out_data.result_block <= res;
            out_data.status       <= st;
            out_data.free_blocks  <= free_now;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
